// File: rtl/core/rwtp_pkg.sv
package rwtp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned AddrW = 20;
  localparam int unsigned DataW = 8;
  localparam int unsigned NibW  = 4;

  // ASCII codes the parser reacts to
  localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteW-1:0] CH_NL     = 8'h0A;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;
  localparam logic [ByteW-1:0] CH_COMMA  = 8'h2C;
  localparam logic [ByteW-1:0] CH_SLASH  = 8'h2F;
  localparam logic [ByteW-1:0] CH_ZERO   = 8'h30;
  localparam logic [ByteW-1:0] CH_NINE   = 8'h39;
  localparam logic [ByteW-1:0] CH_UP_A   = 8'h41;
  localparam logic [ByteW-1:0] CH_UP_F   = 8'h46;
  localparam logic [ByteW-1:0] CH_UP_X   = 8'h58;
  localparam logic [ByteW-1:0] CH_LO_A   = 8'h61;
  localparam logic [ByteW-1:0] CH_LO_F   = 8'h66;
  localparam logic [ByteW-1:0] CH_LO_X   = 8'h78;
  localparam logic [ByteW-1:0] CH_LBRACE = 8'h7B;
  localparam logic [ByteW-1:0] HEX_TEN   = 8'h0A;

  typedef enum logic [3:0] {
    PH_LINE_START = 4'd0,
    PH_IGNORE     = 4'd1,
    PH_OPEN       = 4'd2,
    PH_ADDR_ZERO  = 4'd3,
    PH_ADDR_X     = 4'd4,
    PH_ADDR_D1    = 4'd5,
    PH_ADDR_D2    = 4'd6,
    PH_ADDR_D3    = 4'd7,
    PH_ADDR_D4    = 4'd8,
    PH_ADDR_DONE  = 4'd9,
    PH_COMMA      = 4'd10,
    PH_DATA_ZERO  = 4'd11,
    PH_DATA_X     = 4'd12,
    PH_DATA_D1    = 4'd13
  } phase_t;

  typedef struct packed {
    logic             ok;
    logic [NibW-1:0]  nib;
  } hex_t;

  // held character between the input register and the parser
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] text_byte;
  } char_t;

  // parser to result register
  typedef struct packed {
    logic             take;
    logic             load;
    logic [AddrW-1:0] write_address;
    logic [DataW-1:0] write_data;
  } step_t;

  function automatic hex_t hex_decode(logic [ByteW-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.nib = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      h.nib = NibW'(c - CH_ZERO);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      h.nib = NibW'(c - CH_LO_A + HEX_TEN);
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      h.nib = NibW'(c - CH_UP_A + HEX_TEN);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// File: rtl/core/rwtp_byte_if.sv
interface rwtp_byte_if;
  logic                          valid;
  logic                          ready;
  logic [rwtp_pkg::ByteW-1:0]    text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink   (input valid, input text_byte, output ready);
endinterface

// File: rtl/core/rwtp_write_if.sv
interface rwtp_write_if;
  logic                          valid;
  logic                          ready;
  logic [rwtp_pkg::AddrW-1:0]    write_address;
  logic [rwtp_pkg::DataW-1:0]    write_data;

  modport source (output valid, output write_address, output write_data, input ready);
  modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

// File: rtl/core/rwtp_in_stage.sv
module rwtp_in_stage (
  input  logic               clk,
  input  logic               rst,
  rwtp_byte_if.sink          text,
  input  logic               take,
  output rwtp_pkg::char_t    ch
);

  logic                       valid;
  logic [rwtp_pkg::ByteW-1:0] text_byte;

  // free when empty or when the held character moves on this cycle
  assign text.ready = !valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (text.ready) begin
      valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      text_byte <= text.text_byte;
    end
  end

  assign ch.valid     = valid;
  assign ch.text_byte = text_byte;

endmodule

// File: rtl/core/rwtp_fsm.sv
module rwtp_fsm (
  input  logic               clk,
  input  logic               rst,
  input  rwtp_pkg::char_t    ch,
  input  logic               out_free,
  output rwtp_pkg::step_t    step
);

  rwtp_pkg::phase_t              phase, phase_next;
  logic [rwtp_pkg::AddrW-1:0]    address_accumulator, address_accumulator_next;
  logic [rwtp_pkg::NibW-1:0]     data_high_nibble, data_high_nibble_next;

  rwtp_pkg::hex_t                hex;
  logic                          is_blank;
  logic                          is_nl;
  logic                          is_x;
  logic                          emit;
  logic                          take;
  logic [rwtp_pkg::AddrW-1:0]    nib_ext;

  assign hex      = rwtp_pkg::hex_decode(ch.text_byte);
  assign is_blank = (ch.text_byte == rwtp_pkg::CH_SPACE) || (ch.text_byte == rwtp_pkg::CH_TAB);
  assign is_nl    = (ch.text_byte == rwtp_pkg::CH_NL);
  assign is_x     = (ch.text_byte == rwtp_pkg::CH_LO_X) || (ch.text_byte == rwtp_pkg::CH_UP_X);
  assign nib_ext  = {{(rwtp_pkg::AddrW - rwtp_pkg::NibW){1'b0}}, hex.nib};

  // the second value digit completes a record
  assign emit = ch.valid && !is_blank && !is_nl && (phase == rwtp_pkg::PH_DATA_D1) && hex.ok;
  assign take = ch.valid && (!emit || out_free);

  always_comb begin
    phase_next               = phase;
    address_accumulator_next = address_accumulator;
    data_high_nibble_next    = data_high_nibble;
    if (take && !is_blank) begin
      if (is_nl) begin
        phase_next = rwtp_pkg::PH_LINE_START;
      end else begin
        case (phase)
          rwtp_pkg::PH_LINE_START: begin
            if (ch.text_byte == rwtp_pkg::CH_LBRACE) begin
              phase_next = rwtp_pkg::PH_OPEN;
            end else if (ch.text_byte == rwtp_pkg::CH_SLASH) begin
              phase_next = rwtp_pkg::PH_IGNORE;
            end
          end
          rwtp_pkg::PH_IGNORE: begin
            phase_next = rwtp_pkg::PH_IGNORE;
          end
          rwtp_pkg::PH_OPEN: begin
            phase_next = (ch.text_byte == rwtp_pkg::CH_ZERO) ?
                         rwtp_pkg::PH_ADDR_ZERO : rwtp_pkg::PH_IGNORE;
          end
          rwtp_pkg::PH_ADDR_ZERO: begin
            phase_next = is_x ? rwtp_pkg::PH_ADDR_X : rwtp_pkg::PH_IGNORE;
          end
          rwtp_pkg::PH_ADDR_X: begin
            if (hex.ok) begin
              address_accumulator_next = nib_ext << 16;
              phase_next = rwtp_pkg::PH_ADDR_D1;
            end else begin
              phase_next = rwtp_pkg::PH_IGNORE;
            end
          end
          rwtp_pkg::PH_ADDR_D1: begin
            if (hex.ok) begin
              address_accumulator_next = address_accumulator | (nib_ext << 12);
              phase_next = rwtp_pkg::PH_ADDR_D2;
            end else begin
              phase_next = rwtp_pkg::PH_IGNORE;
            end
          end
          rwtp_pkg::PH_ADDR_D2: begin
            if (hex.ok) begin
              address_accumulator_next = address_accumulator | (nib_ext << 8);
              phase_next = rwtp_pkg::PH_ADDR_D3;
            end else begin
              phase_next = rwtp_pkg::PH_IGNORE;
            end
          end
          rwtp_pkg::PH_ADDR_D3: begin
            if (hex.ok) begin
              address_accumulator_next = address_accumulator | (nib_ext << 4);
              phase_next = rwtp_pkg::PH_ADDR_D4;
            end else begin
              phase_next = rwtp_pkg::PH_IGNORE;
            end
          end
          rwtp_pkg::PH_ADDR_D4: begin
            if (hex.ok) begin
              address_accumulator_next = address_accumulator | nib_ext;
              phase_next = rwtp_pkg::PH_ADDR_DONE;
            end else begin
              phase_next = rwtp_pkg::PH_IGNORE;
            end
          end
          rwtp_pkg::PH_ADDR_DONE: begin
            phase_next = (ch.text_byte == rwtp_pkg::CH_COMMA) ?
                         rwtp_pkg::PH_COMMA : rwtp_pkg::PH_IGNORE;
          end
          rwtp_pkg::PH_COMMA: begin
            phase_next = (ch.text_byte == rwtp_pkg::CH_ZERO) ?
                         rwtp_pkg::PH_DATA_ZERO : rwtp_pkg::PH_IGNORE;
          end
          rwtp_pkg::PH_DATA_ZERO: begin
            phase_next = is_x ? rwtp_pkg::PH_DATA_X : rwtp_pkg::PH_IGNORE;
          end
          rwtp_pkg::PH_DATA_X: begin
            if (hex.ok) begin
              data_high_nibble_next = hex.nib;
              phase_next = rwtp_pkg::PH_DATA_D1;
            end else begin
              phase_next = rwtp_pkg::PH_IGNORE;
            end
          end
          rwtp_pkg::PH_DATA_D1: begin
            phase_next = rwtp_pkg::PH_IGNORE;
          end
          default: begin
            phase_next = rwtp_pkg::PH_IGNORE;
          end
        endcase
      end
    end
  end

  always_comb begin
    step.take          = take;
    step.load          = take && emit;
    step.write_address = address_accumulator;
    step.write_data    = {data_high_nibble, hex.nib};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= rwtp_pkg::PH_LINE_START;
      address_accumulator <= '0;
      data_high_nibble    <= '0;
    end else begin
      phase               <= phase_next;
      address_accumulator <= address_accumulator_next;
      data_high_nibble    <= data_high_nibble_next;
    end
  end

endmodule

// File: rtl/core/rwtp_out_stage.sv
module rwtp_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  rwtp_pkg::step_t    step,
  output logic               out_free,
  rwtp_write_if.source       wr
);

  logic                       valid;
  logic [rwtp_pkg::AddrW-1:0] write_address;
  logic [rwtp_pkg::DataW-1:0] write_data;

  assign out_free = !valid || wr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (step.load) begin
      valid <= 1'b1;
    end else if (wr.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.load) begin
      write_address <= step.write_address;
      write_data    <= step.write_data;
    end
  end

  assign wr.valid         = valid;
  assign wr.write_address = write_address;
  assign wr.write_data    = write_data;

endmodule

// File: rtl/core/register_write_text_parser.sv
// Channel  Role    Payload                              Request
// -------  ------  -----------------------------------  -------------------------------
// text     sink    text_byte[7:0]                       one character of settings text
// wr       source  write_address[19:0], write_data[7:0] one register write
//
// One character enters per cycle unless a closing value digit waits on a stalled write;
// a write request passes the input register and then the result register on its way to wr.
// Reset (rst, synchronous) returns the parser to line start and empties both registers.
// A stalled write request holds only the character that would replace it; blanks,
// newlines and characters that close no record keep flowing while wr is stalled.
module register_write_text_parser (
  input  logic          clk,
  input  logic          rst,
  rwtp_byte_if.sink     text,
  rwtp_write_if.source  wr
);

  rwtp_pkg::char_t  ch;
  rwtp_pkg::step_t  step;
  logic             out_free;

  // hold one character ahead of the parser
  rwtp_in_stage u_in (
    .clk  (clk),
    .rst  (rst),
    .text (text),
    .take (step.take),
    .ch   (ch)
  );

  // advance the line phase and build the address and value
  rwtp_fsm u_fsm (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .out_free (out_free),
    .step     (step)
  );

  // hold the finished write request until the sink takes it
  rwtp_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .out_free (out_free),
    .wr       (wr)
  );

endmodule

// File: rtl/core/rwtp_check.sv
module rwtp_check (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [rwtp_pkg::AddrW-1:0] out_address,
  input logic [rwtp_pkg::DataW-1:0] out_data
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("write request present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_address) && $stable(out_data))
    else $error("stalled write request changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("text stalled without a stalled write request");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("write request without a character taken two cycles before");

endmodule

bind register_write_text_parser rwtp_check u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (text.valid),
  .in_ready    (text.ready),
  .out_valid   (wr.valid),
  .out_ready   (wr.ready),
  .out_address (wr.write_address),
  .out_data    (wr.write_data)
);

// File: sim/tb_register_write_text_parser.sv
module tb_register_write_text_parser;

  localparam int unsigned RandChars   = 820;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned IdleLimit   = 4000;
  localparam logic [rwtp_pkg::ByteW-1:0] CH_CR = 8'h0D;

  typedef struct packed {
    logic [rwtp_pkg::AddrW-1:0] addr;
    logic [rwtp_pkg::DataW-1:0] data;
  } reg_write_t;

  // One directed line; a typed row carries its write (if any) inline.
  typedef struct {
    string                      txt;
    bit                         typed;
    bit                         has_wr;
    logic [rwtp_pkg::AddrW-1:0] addr;
    logic [rwtp_pkg::DataW-1:0] data;
  } text_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rwtp_byte_if  text_if ();
  rwtp_write_if wr_if ();

  register_write_text_parser i_dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_if),
    .wr   (wr_if)
  );

  always #10 clk = ~clk;

  // Mirror of the parser state, advanced on every accepted character.
  rwtp_pkg::phase_t           exp_phase    = rwtp_pkg::PH_LINE_START;
  logic [rwtp_pkg::AddrW-1:0] exp_addr_acc = '0;
  logic [rwtp_pkg::NibW-1:0]  exp_hi_nib   = '0;

  reg_write_t  pending_writes[$];
  text_row_t   text_rows[$];
  logic [7:0]  line_bytes[$];

  int unsigned chars_sent  = 0;
  int unsigned mismatches  = 0;
  int unsigned idle_run    = 0;
  bit          no_idle     = 1'b0;
  bit          hold_long   = 1'b0;

  function automatic bit hex_nibble(input logic [7:0] c,
                                    output logic [rwtp_pkg::NibW-1:0] nib);
    logic [7:0] folded;
    folded = c | 8'h20;
    nib = '0;
    if (c >= rwtp_pkg::CH_ZERO && c <= rwtp_pkg::CH_NINE) begin
      nib = c[3:0];
      return 1'b1;
    end
    // fold upper case onto lower case; only A-F and a-f land in a-f
    if (folded >= rwtp_pkg::CH_LO_A && folded <= rwtp_pkg::CH_LO_F) begin
      nib = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [rwtp_pkg::NibW-1:0] nib, input bit upper);
    if (nib < 4'd10) return rwtp_pkg::CH_ZERO + 8'(nib);
    return (upper ? rwtp_pkg::CH_UP_A : rwtp_pkg::CH_LO_A) + 8'(nib) - 8'd10;
  endfunction

  // Advance the mirrored parser by one character; queue the write it closes
  // unless the caller has typed the expectation in already.
  task automatic follow_char(input logic [7:0] c, input bit record);
    logic [rwtp_pkg::NibW-1:0] nib;
    bit                        is_hex;
    bit                        is_x;
    int                        sh;
    is_hex = hex_nibble(c, nib);
    is_x   = (c == rwtp_pkg::CH_LO_X) || (c == rwtp_pkg::CH_UP_X);
    if (c == rwtp_pkg::CH_SPACE || c == rwtp_pkg::CH_TAB) return;
    if (c == rwtp_pkg::CH_NL) begin
      exp_phase = rwtp_pkg::PH_LINE_START;
      return;
    end
    case (exp_phase)
      rwtp_pkg::PH_LINE_START: begin
        if (c == rwtp_pkg::CH_LBRACE) exp_phase = rwtp_pkg::PH_OPEN;
        else if (c == rwtp_pkg::CH_SLASH) exp_phase = rwtp_pkg::PH_IGNORE;
      end
      rwtp_pkg::PH_OPEN:
        exp_phase = (c == rwtp_pkg::CH_ZERO) ? rwtp_pkg::PH_ADDR_ZERO : rwtp_pkg::PH_IGNORE;
      rwtp_pkg::PH_ADDR_ZERO:
        exp_phase = is_x ? rwtp_pkg::PH_ADDR_X : rwtp_pkg::PH_IGNORE;
      rwtp_pkg::PH_ADDR_X, rwtp_pkg::PH_ADDR_D1, rwtp_pkg::PH_ADDR_D2,
      rwtp_pkg::PH_ADDR_D3, rwtp_pkg::PH_ADDR_D4: begin
        if (is_hex) begin
          sh = 4 * (int'(rwtp_pkg::PH_ADDR_D4) - int'(exp_phase));
          if (exp_phase == rwtp_pkg::PH_ADDR_X) exp_addr_acc = '0;
          exp_addr_acc = exp_addr_acc | (rwtp_pkg::AddrW'(nib) << sh);
          exp_phase = rwtp_pkg::phase_t'(exp_phase + 4'd1);
        end else begin
          exp_phase = rwtp_pkg::PH_IGNORE;
        end
      end
      rwtp_pkg::PH_ADDR_DONE:
        exp_phase = (c == rwtp_pkg::CH_COMMA) ? rwtp_pkg::PH_COMMA : rwtp_pkg::PH_IGNORE;
      rwtp_pkg::PH_COMMA:
        exp_phase = (c == rwtp_pkg::CH_ZERO) ? rwtp_pkg::PH_DATA_ZERO : rwtp_pkg::PH_IGNORE;
      rwtp_pkg::PH_DATA_ZERO:
        exp_phase = is_x ? rwtp_pkg::PH_DATA_X : rwtp_pkg::PH_IGNORE;
      rwtp_pkg::PH_DATA_X: begin
        if (is_hex) begin
          exp_hi_nib = nib;
          exp_phase  = rwtp_pkg::PH_DATA_D1;
        end else begin
          exp_phase = rwtp_pkg::PH_IGNORE;
        end
      end
      rwtp_pkg::PH_DATA_D1: begin
        if (is_hex && record)
          pending_writes.push_back(reg_write_t'{exp_addr_acc, {exp_hi_nib, nib}});
        exp_phase = rwtp_pkg::PH_IGNORE;
      end
      default: exp_phase = rwtp_pkg::PH_IGNORE;
    endcase
  endtask

  // Offer one character after a random gap and hold it until it is taken.
  task automatic offer_char(input logic [7:0] c, input bit typed);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    @(negedge clk);
    if (gap > 0) begin
      text_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_if.valid     <= 1'b1;
    text_if.text_byte <= c;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    follow_char(c, !typed);
    chars_sent++;
  endtask

  // Drop valid and hold the text side until every queued write has come out.
  task automatic wait_for_writes();
    @(negedge clk);
    text_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input string txt, input bit typed, input bit has_wr,
                         input logic [rwtp_pkg::AddrW-1:0] addr,
                         input logic [rwtp_pkg::DataW-1:0] data);
    text_row_t r;
    r.txt    = txt;
    r.typed  = typed;
    r.has_wr = has_wr;
    r.addr   = addr;
    r.data   = data;
    text_rows.push_back(r);
  endtask

  // Build one random line: mostly well-formed records with random content and
  // blanks, plus corrupted, truncated, commented-out and pure noise lines.
  task automatic build_line();
    logic [7:0]                 rec[$];
    logic [rwtp_pkg::AddrW-1:0] a;
    logic [rwtp_pkg::DataW-1:0] d;
    int                         kind;
    int                         cut;
    line_bytes.delete();
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       line_bytes.push_back(rwtp_pkg::CH_SPACE);
        1:       line_bytes.push_back(rwtp_pkg::CH_TAB);
        2:       line_bytes.push_back(CH_CR);
        default: line_bytes.push_back(8'($urandom_range(128, 255)));
      endcase
    end
    case ($urandom_range(0, 7))
      0:       a = '1;
      1:       a = '0;
      default: a = rwtp_pkg::AddrW'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       d = '1;
      1:       d = '0;
      default: d = rwtp_pkg::DataW'($urandom);
    endcase
    rec.push_back(rwtp_pkg::CH_LBRACE);
    rec.push_back(rwtp_pkg::CH_ZERO);
    rec.push_back($urandom_range(0, 1) ? rwtp_pkg::CH_UP_X : rwtp_pkg::CH_LO_X);
    for (int i = 4; i >= 0; i--)
      rec.push_back(hex_char(a[4*i +: 4], 1'($urandom_range(0, 1))));
    rec.push_back(rwtp_pkg::CH_COMMA);
    rec.push_back(rwtp_pkg::CH_ZERO);
    rec.push_back($urandom_range(0, 1) ? rwtp_pkg::CH_UP_X : rwtp_pkg::CH_LO_X);
    rec.push_back(hex_char(d[7:4], 1'($urandom_range(0, 1))));
    rec.push_back(hex_char(d[3:0], 1'($urandom_range(0, 1))));
    case (kind)
      6: rec[$urandom_range(0, rec.size() - 1)] = 8'($urandom_range(0, 255));
      7: begin
        cut = $urandom_range(1, rec.size() - 1);
        while (rec.size() > cut) void'(rec.pop_back());
      end
      8: line_bytes.push_back(rwtp_pkg::CH_SLASH);
      9: begin
        rec.delete();
        repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    foreach (rec[i]) begin
      line_bytes.push_back(rec[i]);
      if ($urandom_range(0, 5) == 0)
        line_bytes.push_back($urandom_range(0, 1) ? rwtp_pkg::CH_SPACE : rwtp_pkg::CH_TAB);
    end
    if (kind <= 5 && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) line_bytes.push_back(8'($urandom_range(0, 255)));
    if (kind != 9 || $urandom_range(0, 1) == 1) line_bytes.push_back(rwtp_pkg::CH_NL);
  endtask

  // Write side: stall a random number of cycles per request, or one long
  // stretch when asked, then compare the request against the oldest expectation.
  initial begin : write_sink
    int         stall;
    reg_write_t want;
    wr_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_long) begin
        stall     = HoldCycles;
        hold_long = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 5);
      end
      @(negedge clk);
      if (stall > 0) begin
        wr_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      wr_if.ready <= 1'b1;
      @(posedge clk);
      while (!wr_if.valid) @(posedge clk);
      if (pending_writes.size() == 0) begin
        $error("unexpected write request: write_address %h write_data %h",
               wr_if.write_address, wr_if.write_data);
        mismatches++;
      end else begin
        want = pending_writes.pop_front();
        if (wr_if.write_address !== want.addr) begin
          $error("write_address: expected %h, actual %h", want.addr, wr_if.write_address);
          mismatches++;
        end
        if (wr_if.write_data !== want.data) begin
          $error("write_data: expected %h, actual %h", want.data, wr_if.write_data);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither side moves a request for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((text_if.valid && text_if.ready) || (wr_if.valid && wr_if.ready)) begin
        idle_run <= 0;
      end else if (idle_run >= IdleLimit) begin
        $display("** register_write_text_parser: FAILED **");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin : text_source
    int unsigned rand_start;
    bit          pressure_done;
    string       press_line;
    text_if.valid     = 1'b0;
    text_if.text_byte = '0;
    pressure_done     = 1'b0;
    press_line        = "{0x2468A,0xC5\n";

    // Typed rows: the write is plain from the text. Others go through the mirror.
    add_row("{0x00000,0x00\n", 1, 1, 20'h00000, 8'h00);
    add_row("{0xFFFFF,0xff\n", 1, 1, 20'hFFFFF, 8'hFF);
    add_row("\377\200\r{0xabcde,0XAB\n", 1, 1, 20'hABCDE, 8'hAB);
    add_row("/{0x12345,0x67\n", 1, 0, '0, '0);
    add_row(" \t{ 0x1 2\t3 4 5 ,0 x 9a \n", 1, 1, 20'h12345, 8'h9A);
    add_row("{0x12345,0x6g\n", 1, 0, '0, '0);
    add_row("{0x4321\n", 1, 0, '0, '0);
    add_row("{0x5\n", 1, 0, '0, '0);
    add_row("{0xA0000,0x5a\n", 0, 0, '0, '0);
    add_row("{1\n", 0, 0, '0, '0);
    add_row("{0y\n", 0, 0, '0, '0);
    add_row("{0xz\n", 0, 0, '0, '0);
    add_row("{0x12345;\n", 0, 0, '0, '0);
    add_row("{0x12345,1\n", 0, 0, '0, '0);
    add_row("{0x12345,0X\n", 0, 0, '0, '0);
    add_row("{0x12345,0xq\n", 0, 0, '0, '0);
    add_row("{0xc0FfE,0x3C},{0x11111,0x22\n", 0, 0, '0, '0);
    add_row("q{0x0F0F0,0xE1\n", 0, 0, '0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // a NUL at line start is skipped like any other stray byte
    offer_char(8'h00, 1'b1);
    foreach (text_rows[r]) begin
      if (text_rows[r].typed && text_rows[r].has_wr)
        pending_writes.push_back(reg_write_t'{text_rows[r].addr, text_rows[r].data});
      for (int i = 0; i < text_rows[r].txt.len(); i++)
        offer_char(text_rows[r].txt[i], text_rows[r].typed);
    end
    wait_for_writes();

    rand_start = chars_sent;
    while (chars_sent - rand_start < RandChars) begin
      if (!pressure_done && chars_sent - rand_start > RandChars / 2) begin
        // Stall the write side for a long stretch while complete records keep
        // coming, so the block backs up and blocks text; then pause until drained.
        pressure_done = 1'b1;
        hold_long     = 1'b1;
        no_idle       = 1'b1;
        repeat (6) begin
          for (int i = 0; i < press_line.len(); i++) offer_char(press_line[i], 1'b0);
          build_line();
          foreach (line_bytes[i]) offer_char(line_bytes[i], 1'b0);
        end
        no_idle = 1'b0;
        wait_for_writes();
      end
      if ($urandom_range(0, 7) == 0) no_idle = !no_idle;
      build_line();
      foreach (line_bytes[i]) offer_char(line_bytes[i], 1'b0);
    end

    wait_for_writes();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending_writes.size() == 0) begin
      $display("** register_write_text_parser: PASSED **");
    end else begin
      $display("** register_write_text_parser: FAILED **");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/rwtp_pkg.sv
rtl/core/rwtp_byte_if.sv
rtl/core/rwtp_write_if.sv
rtl/core/rwtp_in_stage.sv
rtl/core/rwtp_fsm.sv
rtl/core/rwtp_out_stage.sv
rtl/core/register_write_text_parser.sv
rtl/core/rwtp_check.sv
sim/tb_register_write_text_parser.sv
